[sv/assert_macros.svh]
// Assertion helper macros shared by the RTL files.
// Expects i_clk and i_rst_n in the scope of use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define WTCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define WTCM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[sv/wtcm_pkg.sv]
// Shared types and constants for the wall texture column mapper.
// No dependencies; imported by every module of the block.
package wtcm_pkg;

    localparam int unsigned DEF_MAX_TEXTURE_SIZE = 1024;
    localparam int unsigned DEF_MAX_SCREEN_ROWS  = 2048;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT  = 3'd4;

    // datapath widths
    localparam int unsigned STEP_W = 27;   // vertical step, unsigned Q11.16
    localparam int unsigned LH_W   = 16;   // slice height

    // action codes
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // texture codes
    localparam logic [1:0] TEX_WEST  = 2'd0;
    localparam logic [1:0] TEX_EAST  = 2'd1;
    localparam logic [1:0] TEX_NORTH = 2'd2;
    localparam logic [1:0] TEX_SOUTH = 2'd3;

    typedef struct packed {
        logic capture;    // register a load item
        logic mul_hit;    // distance * direction, fractional hit
        logic div_start;  // launch step division
        logic mul_col;    // fraction * width, texel column
        logic mul_pos;    // offset * step
        logic commit;     // saturate start position, arm column
        logic advance;    // emit one row and step on
    } t_cmd;

    typedef struct packed {
        logic active;
        logic div_busy;
    } t_status;

endpackage

[sv/wtcm_div.sv]
// Restoring divider, one quotient bit per cycle, for the vertical step.
// Depends on wtcm_pkg.
module wtcm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [wtcm_pkg::STEP_W-1:0] i_dividend,
    input  logic [wtcm_pkg::LH_W-1:0]   i_divisor,
    output logic                        o_busy,
    output logic [wtcm_pkg::STEP_W-1:0] o_quotient
);
    import wtcm_pkg::*;

    localparam int unsigned CNT_W = $clog2(STEP_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic [STEP_W-1:0] r_num;   // dividend shifts out, quotient shifts in
    logic [LH_W-1:0]   r_rem;
    logic [LH_W-1:0]   r_den;
    logic [LH_W:0]     shifted;
    logic [LH_W:0]     diff;
    logic              fits;

    assign shifted = {r_rem, r_num[STEP_W-1]};
    assign fits    = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(STEP_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? diff[LH_W-1:0] : shifted[LH_W-1:0];
            r_num <= {r_num[STEP_W-2:0], fits};
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_num;

endmodule

[sv/wtcm_ctrl.sv]
// Sequencer for the column mapper: input/output handshake and load steps.
// Depends on wtcm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wtcm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_action,
    input  logic              i_out_ready,
    input  wtcm_pkg::t_status i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output wtcm_pkg::t_cmd    o_cmd
);
    import wtcm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIT,
        S_COL,
        S_DIV,
        S_POS,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = accept && (i_action == ACT_LOAD);
        o_cmd.advance   = accept && (i_action == ACT_ADVANCE) && i_sts.active;
        o_cmd.mul_hit   = r_state == S_HIT;
        o_cmd.div_start = r_state == S_HIT;
        o_cmd.mul_col   = r_state == S_COL;
        o_cmd.mul_pos   = r_state == S_POS;
        o_cmd.commit    = r_state == S_COMMIT;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_HIT;
                end
            end
            S_HIT:    n_state = S_COL;
            S_COL:    n_state = S_DIV;
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_POS;
                end
            end
            S_POS:    n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `WTCM_ASSERT(a_load_starts, o_cmd.capture |=> r_state == S_HIT, "load did not start sequence")
    `WTCM_NEVER(a_div_done, (r_state == S_POS) && i_sts.div_busy, "step used before divide done")
    `WTCM_ASSERT(a_out_cause, $rose(r_out_valid) |-> $past(o_cmd.advance), "result without advance")

endmodule

[sv/wtcm_dp.sv]
// Datapath of the column mapper: config registers, multiplies, column state, output register.
// Depends on wtcm_pkg and wtcm_div.
module wtcm_dp #(
    parameter int unsigned MAX_TEXTURE_SIZE = wtcm_pkg::DEF_MAX_TEXTURE_SIZE,
    parameter int unsigned MAX_SCREEN_ROWS  = wtcm_pkg::DEF_MAX_SCREEN_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wtcm_pkg::t_cmd                  i_cmd,
    output wtcm_pkg::t_status               o_sts,
    input  logic                            i_cfg_we,
    input  logic [wtcm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wtcm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_hit_side,
    input  logic signed [15:0]              i_dir_x,
    input  logic signed [15:0]              i_dir_y,
    input  logic [23:0]                     i_wall_distance,
    input  logic [15:0]                     i_slice_height,
    input  logic [10:0]                     i_first_row,
    input  logic [10:0]                     i_final_row,
    input  logic [10:0]                     i_screen_column,
    output logic [10:0]                     o_out_column,
    output logic [10:0]                     o_out_row,
    output logic [1:0]                      o_texture_select,
    output logic [9:0]                      o_texel_x,
    output logic [9:0]                      o_texel_y,
    output logic                            o_last
);
    import wtcm_pkg::*;

    localparam logic [12:0] TEX_MAX = 13'(MAX_TEXTURE_SIZE);
    localparam logic [12:0] ROW_MAX = 13'(MAX_SCREEN_ROWS);

    // configuration
    logic [23:0] r_player_x;
    logic [23:0] r_player_y;
    logic [10:0] r_tex_w;
    logic [10:0] r_tex_h;
    logic [11:0] r_scr_h;
    logic [10:0] tex_w;
    logic [10:0] tex_h;
    logic [11:0] scr_h;

    // load staging
    logic               r_side;
    logic               r_mirror;
    logic signed [15:0] r_dx;
    logic signed [15:0] r_dy;
    logic [23:0]        r_dist;
    logic [LH_W-1:0]    r_lh;
    logic signed [17:0] r_offset;
    logic [15:0]        r_frac;
    logic signed [45:0] r_pos_prod;

    // column state
    logic               r_active;
    logic [1:0]         r_tex_sel;
    logic [9:0]         r_texel_col;
    logic [STEP_W-1:0]  r_step;
    logic signed [31:0] r_pos;
    logic [10:0]        r_cur_row;
    logic [10:0]        r_end_row;
    logic [10:0]        r_column;

    // output register
    logic [10:0] r_o_column;
    logic [10:0] r_o_row;
    logic [1:0]  r_o_tex;
    logic [9:0]  r_o_tx;
    logic [9:0]  r_o_ty;
    logic        r_o_last;

    logic [LH_W-1:0]    lh_fix;
    logic signed [17:0] n_offset;
    logic [1:0]         n_tex_sel;
    logic signed [15:0] hit_dir;
    logic [23:0]        hit_base;
    logic signed [40:0] hit_prod;
    logic [15:0]        n_frac;
    logic [26:0]        col_prod;
    logic [10:0]        col_raw;
    logic [10:0]        col_m;
    logic [STEP_W-1:0]  quotient;
    logic               div_busy;
    logic signed [45:0] pos_prod;
    logic signed [31:0] start_pos;
    logic signed [32:0] pos_sum;
    logic signed [31:0] n_pos;
    logic [10:0]        tx_full;
    logic [14:0]        ty_int;
    logic [14:0]        ty_lim;
    logic [14:0]        ty_full;
    logic               is_last;

    // effective sizes: a zero texture size acts as one, oversize clamps to the maximum
    always_comb begin
        if (r_tex_w == '0) begin
            tex_w = 11'd1;
        end else if ({2'b00, r_tex_w} > TEX_MAX) begin
            tex_w = TEX_MAX[10:0];
        end else begin
            tex_w = r_tex_w;
        end
        if (r_tex_h == '0) begin
            tex_h = 11'd1;
        end else if ({2'b00, r_tex_h} > TEX_MAX) begin
            tex_h = TEX_MAX[10:0];
        end else begin
            tex_h = r_tex_h;
        end
        if ({1'b0, r_scr_h} > ROW_MAX) begin
            scr_h = ROW_MAX[11:0];
        end else begin
            scr_h = r_scr_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_x <= '0;
            r_player_y <= '0;
            r_tex_w    <= 11'd64;
            r_tex_h    <= 11'd64;
            r_scr_h    <= 12'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PLAYER_X:       r_player_x <= i_cfg_data[23:0];
                CFG_PLAYER_Y:       r_player_y <= i_cfg_data[23:0];
                CFG_TEXTURE_WIDTH:  r_tex_w    <= i_cfg_data[10:0];
                CFG_TEXTURE_HEIGHT: r_tex_h    <= i_cfg_data[10:0];
                CFG_SCREEN_HEIGHT:  r_scr_h    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // load: texture pick and row offset
    always_comb begin
        lh_fix = (i_slice_height == '0) ? LH_W'(1) : i_slice_height;
        n_offset = $signed({7'b0, i_first_row}) - $signed({7'b0, scr_h[11:1]})
                   + $signed({3'b0, lh_fix[15:1]});
        if (!i_hit_side && i_dir_x[15]) begin
            n_tex_sel = TEX_WEST;
        end else if (!i_hit_side && (i_dir_x != '0)) begin
            n_tex_sel = TEX_EAST;
        end else if (i_hit_side && i_dir_y[15]) begin
            n_tex_sel = TEX_NORTH;
        end else begin
            n_tex_sel = TEX_SOUTH;
        end
    end

    // hit fraction: only the low 16 bits of player + floor(dist*dir/2^14) matter
    assign hit_dir  = r_side ? r_dx : r_dy;
    assign hit_base = r_side ? r_player_x : r_player_y;
    assign hit_prod = $signed({1'b0, r_dist}) * hit_dir;
    assign n_frac   = hit_base[15:0] + hit_prod[29:14];

    assign col_prod = 27'(r_frac) * 27'(tex_w);
    assign col_raw  = col_prod[26:16];
    assign col_m    = r_mirror ? (tex_w - col_raw - 11'd1) : col_raw;

    wtcm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({tex_h, 16'b0}),
        .i_divisor  (r_lh),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign pos_prod = r_offset * $signed({1'b0, quotient});

    always_comb begin
        if (!r_pos_prod[45] && (|r_pos_prod[44:31])) begin
            start_pos = 32'sh7FFF_FFFF;
        end else if (r_pos_prod[45] && !(&r_pos_prod[44:31])) begin
            start_pos = 32'sh8000_0000;
        end else begin
            start_pos = r_pos_prod[31:0];
        end
    end

    // advance: step with saturation at the top, clamp texel coordinates
    assign pos_sum = {r_pos[31], r_pos} + $signed({6'b0, r_step});
    assign n_pos   = (pos_sum[32] != pos_sum[31]) ? 32'sh7FFF_FFFF : pos_sum[31:0];
    assign tx_full = ({1'b0, r_texel_col} > (tex_w - 11'd1)) ? (tex_w - 11'd1)
                                                             : {1'b0, r_texel_col};
    assign ty_int  = r_pos[30:16];
    assign ty_lim  = {4'b0, tex_h - 11'd1};
    assign ty_full = r_pos[31] ? '0 : ((ty_int > ty_lim) ? ty_lim : ty_int);
    assign is_last = r_cur_row == r_end_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.commit) begin
            r_active <= r_cur_row <= r_end_row;
        end else if (i_cmd.advance && is_last) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_side    <= i_hit_side;
            r_mirror  <= (n_tex_sel == TEX_EAST) || (n_tex_sel == TEX_NORTH);
            r_dx      <= i_dir_x;
            r_dy      <= i_dir_y;
            r_dist    <= i_wall_distance;
            r_lh      <= lh_fix;
            r_offset  <= n_offset;
            r_tex_sel <= n_tex_sel;
            r_cur_row <= i_first_row;
            r_end_row <= i_final_row;
            r_column  <= i_screen_column;
        end
        if (i_cmd.mul_hit) begin
            r_frac <= n_frac;
        end
        if (i_cmd.mul_col) begin
            r_texel_col <= col_m[9:0];
        end
        if (i_cmd.mul_pos) begin
            r_pos_prod <= pos_prod;
        end
        if (i_cmd.commit) begin
            r_step <= quotient;
            r_pos  <= start_pos;
        end
        if (i_cmd.advance) begin
            r_o_column <= r_column;
            r_o_row    <= r_cur_row;
            r_o_tex    <= r_tex_sel;
            r_o_tx     <= tx_full[9:0];
            r_o_ty     <= ty_full[9:0];
            r_o_last   <= is_last;
            r_pos      <= n_pos;
            r_cur_row  <= r_cur_row + 11'd1;
        end
    end

    assign o_sts.active   = r_active;
    assign o_sts.div_busy = div_busy;

    assign o_out_column     = r_o_column;
    assign o_out_row        = r_o_row;
    assign o_texture_select = r_o_tex;
    assign o_texel_x        = r_o_tx;
    assign o_texel_y        = r_o_ty;
    assign o_last           = r_o_last;

endmodule

[sv/wall_texture_column_mapper_top.sv]
// Top level of the wall texture column mapper: sequencer plus datapath.
// Depends on wtcm_pkg, wtcm_ctrl, wtcm_dp (and wtcm_div below it).
//
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     action, hit, direction, distance, rows, column
// out       output     o_out_valid / i_out_ready   column, row, texture, texel x/y, last
// cfg       input      i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// Advance items: one transfer per cycle while the output is taken; each row result sits in an output register,
//   and the next item is taken in the same cycle the held result is taken.
// Load items: after the transfer, ready stays low until the load sequence ends, which is
//   governed by the 27-step serial divider for the vertical step; the hit and column
//   multiplies overlap it, the position multiply and commit follow it.
// Reset: synchronous, active low; clears the sequencer, divider count and active flag, sets config to defaults.
// A stalled output blocks further input only while a result is still held.
module wall_texture_column_mapper_top #(
    parameter int unsigned MAX_TEXTURE_SIZE = wtcm_pkg::DEF_MAX_TEXTURE_SIZE,
    parameter int unsigned MAX_SCREEN_ROWS  = wtcm_pkg::DEF_MAX_SCREEN_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_action,
    input  logic                            i_hit_side,
    input  logic signed [15:0]              i_dir_x,
    input  logic signed [15:0]              i_dir_y,
    input  logic [23:0]                     i_wall_distance,
    input  logic [15:0]                     i_slice_height,
    input  logic [10:0]                     i_first_row,
    input  logic [10:0]                     i_final_row,
    input  logic [10:0]                     i_screen_column,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [10:0]                     o_out_column,
    output logic [10:0]                     o_out_row,
    output logic [1:0]                      o_texture_select,
    output logic [9:0]                      o_texel_x,
    output logic [9:0]                      o_texel_y,
    output logic                            o_last,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [wtcm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wtcm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wtcm_pkg::*;

    t_cmd    cmd;   // sequencer -> datapath strobes
    t_status sts;   // datapath -> sequencer: column active, divider busy

    // Sequencer: takes a load, walks hit multiply, column multiply, divide wait,
    // position multiply and commit; advances go straight to the output register.
    wtcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Datapath: config registers, per-column state, arithmetic and result payload.
    wtcm_dp #(
        .MAX_TEXTURE_SIZE (MAX_TEXTURE_SIZE),
        .MAX_SCREEN_ROWS  (MAX_SCREEN_ROWS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_hit_side       (i_hit_side),
        .i_dir_x          (i_dir_x),
        .i_dir_y          (i_dir_y),
        .i_wall_distance  (i_wall_distance),
        .i_slice_height   (i_slice_height),
        .i_first_row      (i_first_row),
        .i_final_row      (i_final_row),
        .i_screen_column  (i_screen_column),
        .o_out_column     (o_out_column),
        .o_out_row        (o_out_row),
        .o_texture_select (o_texture_select),
        .o_texel_x        (o_texel_x),
        .o_texel_y        (o_texel_y),
        .o_last           (o_last)
    );

endmodule
